>>> hw/rtl/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared widths, defaults, request modes and sequencer states for the disjoint-set store.
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

    // Fixed field widths
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;

    // Defaults
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int COUNT_RESET      = 4096;

    // Request modes
    localparam logic MODE_FIND = 1'b0;
    localparam logic MODE_JOIN = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_PACK,
        ST_FIN,
        ST_MERGE,
        ST_MERGE2,
        ST_RESP
    } dsu_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/dsu_ram.sv
// ----------------------------------------------------------------------------
// dsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/disjoint_set_union_top.sv
// ----------------------------------------------------------------------------
// disjoint_set_union_top
// Union-find store with path compression and union by size.
// ----------------------------------------------------------------------------
// One item at a time. From the accepting cycle to the load of the result
// register, a find passes an accept step, a walk step for each entry read
// up to and including the root, a repoint step for each entry on the way
// back, a finish step and the load. A join runs two finds back to back and,
// when the two roots differ, adds the merge writes in ST_MERGE and
// ST_MERGE2. An out-of-range item goes straight from accept to the load.
// The load step repeats while a previous result still waits under
// out_stall. Every step is bounded by the single read and single write port
// of the link memory. After reset and after every element_count write, a
// clearing pass resets every entry to a singleton; in_stall stays high
// during it.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_set_union_top #(
    parameter int MAX_ELEMENTS = dsu_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [dsu_pkg::CNT_W-1:0] element_count,
    // request channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      mode,
    input  wire logic [dsu_pkg::IDX_W-1:0] first_index,
    input  wire logic [dsu_pkg::IDX_W-1:0] second_index,
    // result channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic      [dsu_pkg::IDX_W-1:0] root_index,
    output logic                           merged,
    output logic                           out_of_range
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int EW = AW + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ELEMENTS - 1);
    localparam int CNT_INIT_I = (dsu_pkg::COUNT_RESET > MAX_ELEMENTS) ?
                                MAX_ELEMENTS : dsu_pkg::COUNT_RESET;
    localparam logic [dsu_pkg::CNT_W-1:0] CNT_INIT = dsu_pkg::CNT_W'(CNT_INIT_I);
    // entry: MSB set = root, low bits hold size-1; MSB clear = parent index
    localparam logic [EW-1:0] ENTRY_SINGLE = {1'b1, {AW{1'b0}}};

    dsu_pkg::dsu_state_t state_reg, state_next;

    logic [dsu_pkg::CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          mode_reg, mode_next;
    logic          second_reg, second_next;
    logic [AW-1:0] b_addr_reg, b_addr_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] root_reg, root_next;
    logic [AW-1:0] size_reg, size_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic [AW-1:0] sa_reg, sa_next;
    logic [AW-1:0] res_root_reg, res_root_next;
    logic          res_merged_reg, res_merged_next;
    logic          res_oor_reg, res_oor_next;

    logic                      out_valid_reg, out_valid_next;
    logic [dsu_pkg::IDX_W-1:0] root_index_reg, root_index_next;
    logic                      merged_reg, merged_next;
    logic                      out_of_range_reg, out_of_range_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          rd_is_root;
    logic [AW-1:0] rd_low;

    logic          cfg_wr;
    logic          in_accept;
    logic          bad;
    logic          out_free;
    logic          keep_a;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;

    dsu_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ELEMENTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid & cfg_ready;
    assign in_stall   = (state_reg != dsu_pkg::ST_IDLE);
    assign in_accept  = in_valid & ~in_stall;
    assign out_free   = ~out_valid_reg | ~out_stall;
    assign rd_is_root = rd_data[AW];
    assign rd_low     = rd_data[AW-1:0];
    assign a_addr     = AW'(first_index);
    assign b_addr     = AW'(second_index);
    assign bad        = (dsu_pkg::CNT_W'(first_index) >= count_reg) ||
                        ((mode == dsu_pkg::MODE_JOIN) &&
                         (dsu_pkg::CNT_W'(second_index) >= count_reg));
    assign keep_a     = (sa_reg >= size_reg);

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr)
        begin
            if (32'(element_count) > 32'(MAX_ELEMENTS))
            begin
                count_next = dsu_pkg::CNT_W'(MAX_ELEMENTS);
            end
            else
            begin
                count_next = element_count;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsu_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = dsu_pkg::ST_IDLE;
                end
            end
            dsu_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = bad ? dsu_pkg::ST_RESP : dsu_pkg::ST_WALK;
                end
            end
            dsu_pkg::ST_WALK:
            begin
                if (rd_is_root)
                begin
                    state_next = (cur_reg == start_reg) ? dsu_pkg::ST_FIN : dsu_pkg::ST_PACK;
                end
            end
            dsu_pkg::ST_PACK:
            begin
                if (rd_low == root_reg)
                begin
                    state_next = dsu_pkg::ST_FIN;
                end
            end
            dsu_pkg::ST_FIN:
            begin
                if ((mode_reg == dsu_pkg::MODE_JOIN) && !second_reg)
                begin
                    state_next = dsu_pkg::ST_WALK;
                end
                else if ((mode_reg == dsu_pkg::MODE_FIND) || (ra_reg == root_reg))
                begin
                    state_next = dsu_pkg::ST_RESP;
                end
                else
                begin
                    state_next = dsu_pkg::ST_MERGE;
                end
            end
            dsu_pkg::ST_MERGE:  state_next = dsu_pkg::ST_MERGE2;
            dsu_pkg::ST_MERGE2: state_next = dsu_pkg::ST_RESP;
            dsu_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = dsu_pkg::ST_IDLE;
                end
            end
            default:            state_next = dsu_pkg::ST_IDLE;
        endcase
        // a count write restarts the clearing pass
        if (cfg_wr)
        begin
            state_next = dsu_pkg::ST_CLEAR;
        end
    end

    // datapath and memory control
    always_comb
    begin
        clr_cnt_next      = clr_cnt_reg;
        mode_next         = mode_reg;
        second_next       = second_reg;
        b_addr_next       = b_addr_reg;
        start_next        = start_reg;
        cur_next          = cur_reg;
        root_next         = root_reg;
        size_next         = size_reg;
        ra_next           = ra_reg;
        sa_next           = sa_reg;
        res_root_next     = res_root_reg;
        res_merged_next   = res_merged_reg;
        res_oor_next      = res_oor_reg;
        out_valid_next    = out_valid_reg & out_stall;
        root_index_next   = root_index_reg;
        merged_next       = merged_reg;
        out_of_range_next = out_of_range_reg;
        wr_en             = 1'b0;
        wr_addr           = cur_reg;
        wr_data           = {1'b0, root_reg};
        rd_addr           = cur_reg;

        unique case (state_reg)
            dsu_pkg::ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = ENTRY_SINGLE;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            dsu_pkg::ST_IDLE:
            begin
                rd_addr = a_addr;
                if (in_accept)
                begin
                    mode_next       = mode;
                    b_addr_next     = b_addr;
                    second_next     = 1'b0;
                    start_next      = a_addr;
                    cur_next        = a_addr;
                    res_root_next   = '0;
                    res_merged_next = 1'b0;
                    res_oor_next    = bad;
                end
            end
            dsu_pkg::ST_WALK:
            begin
                if (rd_is_root)
                begin
                    root_next = cur_reg;
                    size_next = rd_low;
                    cur_next  = start_reg;
                    rd_addr   = start_reg;
                end
                else
                begin
                    cur_next = rd_low;
                    rd_addr  = rd_low;
                end
            end
            dsu_pkg::ST_PACK:
            begin
                // cur_reg is a child on the path: point it at the root
                wr_en    = 1'b1;
                wr_addr  = cur_reg;
                wr_data  = {1'b0, root_reg};
                cur_next = rd_low;
                rd_addr  = rd_low;
            end
            dsu_pkg::ST_FIN:
            begin
                if ((mode_reg == dsu_pkg::MODE_JOIN) && !second_reg)
                begin
                    ra_next     = root_reg;
                    sa_next     = size_reg;
                    second_next = 1'b1;
                    start_next  = b_addr_reg;
                    cur_next    = b_addr_reg;
                    rd_addr     = b_addr_reg;
                end
                else if (mode_reg == dsu_pkg::MODE_FIND)
                begin
                    res_root_next = root_reg;
                end
                else
                begin
                    res_root_next = ra_reg;
                end
            end
            dsu_pkg::ST_MERGE:
            begin
                // larger set wins, first root on a tie
                wr_en           = 1'b1;
                wr_addr         = keep_a ? ra_reg : root_reg;
                wr_data         = {1'b1, AW'(sa_reg + size_reg + 1'b1)};
                res_root_next   = keep_a ? ra_reg : root_reg;
                cur_next        = keep_a ? root_reg : ra_reg;
                res_merged_next = 1'b1;
            end
            dsu_pkg::ST_MERGE2:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = {1'b0, res_root_reg};
            end
            dsu_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    root_index_next   = dsu_pkg::IDX_W'(res_root_reg);
                    merged_next       = res_merged_reg;
                    out_of_range_next = res_oor_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase

        if (cfg_wr)
        begin
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsu_pkg::ST_CLEAR;
            count_reg     <= CNT_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= dsu_pkg::MODE_FIND;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg       <= b_addr_next;
        start_reg        <= start_next;
        cur_reg          <= cur_next;
        root_reg         <= root_next;
        size_reg         <= size_next;
        ra_reg           <= ra_next;
        sa_reg           <= sa_next;
        res_root_reg     <= res_root_next;
        res_merged_reg   <= res_merged_next;
        res_oor_reg      <= res_oor_next;
        root_index_reg   <= root_index_next;
        merged_reg       <= merged_next;
        out_of_range_reg <= out_of_range_next;
    end

    assign out_valid    = out_valid_reg;
    assign root_index   = root_index_reg;
    assign merged       = merged_reg;
    assign out_of_range = out_of_range_reg;

endmodule

`default_nettype wire
